// ----- sv/c2hkr_pkg.sv -----
// c2hkr_pkg: shared types, constants and helpers of the character to keyboard report encoder
// depends on nothing; used by c2hkr_ctrl, c2hkr_dpath and char_to_hid_key_report
package c2hkr_pkg;

   localparam int ASCII_DEPTH_DEF = 128;
   localparam int UTF8_DEPTH_DEF  = 64;
   localparam int EXT_DEPTH_DEF   = 64;
   localparam int KEY_SLOTS_DEF   = 6;

   localparam int MAX_SLOTS  = 6;
   localparam int CODE_BYTES = 4;
   localparam int SCAN_W     = 9;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ASCII_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UTF8_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_COUNT   = 2'd2;

   typedef enum logic [2:0] {
      OP_LOAD_ASCII = 3'd0,
      OP_LOAD_UTF8  = 3'd1,
      OP_LOAD_EXT   = 3'd2,
      OP_PRESS_CHAR = 3'd3,
      OP_TYPE_CHAR  = 3'd4,
      OP_PRESS_KEY  = 3'd5,
      OP_PRESS_MOD  = 3'd6,
      OP_RELEASE    = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ASCII,
      ST_UTF,
      ST_EXT,
      ST_PRESS,
      ST_EMIT,
      ST_RELEASE
   } ctl_state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic ascii_read;
      logic take_ascii;
      logic take_utf;
      logic take_ext;
      logic take_raw;
      logic scan_clear;
      logic scan_utf;
      logic scan_ext;
      logic press;
      logic or_mods;
      logic release_all;
      logic emit;
      logic emit_last;
   } ctl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   ascii_sel;
      logic   utf_hit;
      logic   utf_done;
      logic   ext_hit;
      logic   ext_done;
      logic   slot_free;
   } dp_status_type;

   // number of leading code bytes that match; zero when the entry does not match
   function automatic logic [2:0] match_len(input logic [31:0] code, input logic [31:0] chr);
      logic [2:0] res;
      logic       stop;
      res  = 3'd0;
      stop = 1'b0;
      for (int j = 0; j < CODE_BYTES; j++) begin
         if (!stop) begin
            if (code[8*j +: 8] == 8'd0) begin
               stop = 1'b1;
            end else if (code[8*j +: 8] == chr[8*j +: 8]) begin
               res = res + 3'd1;
            end else begin
               res  = 3'd0;
               stop = 1'b1;
            end
         end
      end
      return res;
   endfunction

endpackage

// ----- sv/c2hkr_ctrl.sv -----
// c2hkr_ctrl: sequencing state machine of the encoder
// depends on c2hkr_pkg; drives the datapath through ctl_cmd_type, reads dp_status_type
module c2hkr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  c2hkr_pkg::dp_status_type status,
   output logic                     busy,
   output c2hkr_pkg::ctl_cmd_type   cmd
);

   c2hkr_pkg::ctl_state_type state_ff, state_in;
   logic                     is_type;

   assign is_type = (status.op == c2hkr_pkg::OP_TYPE_CHAR);
   assign busy    = (state_ff != c2hkr_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c2hkr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         c2hkr_pkg::ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = c2hkr_pkg::ST_DISPATCH;
            end
         end
         c2hkr_pkg::ST_DISPATCH: begin
            case (status.op)
               c2hkr_pkg::OP_LOAD_ASCII,
               c2hkr_pkg::OP_LOAD_UTF8,
               c2hkr_pkg::OP_LOAD_EXT: begin
                  cmd.load = 1'b1;
                  state_in = c2hkr_pkg::ST_IDLE;
               end
               c2hkr_pkg::OP_PRESS_CHAR,
               c2hkr_pkg::OP_TYPE_CHAR: begin
                  if (status.ascii_sel) begin
                     cmd.ascii_read = 1'b1;
                     state_in       = c2hkr_pkg::ST_ASCII;
                  end else begin
                     cmd.scan_clear = 1'b1;
                     state_in       = c2hkr_pkg::ST_UTF;
                  end
               end
               c2hkr_pkg::OP_PRESS_KEY: begin
                  cmd.take_raw = 1'b1;
                  state_in     = c2hkr_pkg::ST_PRESS;
               end
               c2hkr_pkg::OP_PRESS_MOD: begin
                  cmd.or_mods = 1'b1;
                  state_in    = c2hkr_pkg::ST_EMIT;
               end
               default: begin
                  state_in = c2hkr_pkg::ST_RELEASE;
               end
            endcase
         end
         c2hkr_pkg::ST_ASCII: begin
            cmd.take_ascii = 1'b1;
            state_in       = c2hkr_pkg::ST_PRESS;
         end
         c2hkr_pkg::ST_UTF: begin
            if (status.utf_hit) begin
               cmd.take_utf = 1'b1;
               state_in     = c2hkr_pkg::ST_PRESS;
            end else if (status.utf_done) begin
               cmd.scan_clear = 1'b1;
               state_in       = c2hkr_pkg::ST_EXT;
            end else begin
               cmd.scan_utf = 1'b1;
            end
         end
         c2hkr_pkg::ST_EXT: begin
            if (status.ext_hit) begin
               cmd.take_ext = 1'b1;
               state_in     = c2hkr_pkg::ST_PRESS;
            end else if (status.ext_done) begin
               state_in = is_type ? c2hkr_pkg::ST_RELEASE : c2hkr_pkg::ST_IDLE;
            end else begin
               cmd.scan_ext = 1'b1;
            end
         end
         c2hkr_pkg::ST_PRESS: begin
            if (status.slot_free) begin
               cmd.press = 1'b1;
               state_in  = c2hkr_pkg::ST_EMIT;
            end else begin
               state_in = is_type ? c2hkr_pkg::ST_RELEASE : c2hkr_pkg::ST_IDLE;
            end
         end
         c2hkr_pkg::ST_EMIT: begin
            cmd.emit      = 1'b1;
            cmd.emit_last = !is_type;
            state_in      = is_type ? c2hkr_pkg::ST_RELEASE : c2hkr_pkg::ST_IDLE;
         end
         c2hkr_pkg::ST_RELEASE: begin
            cmd.release_all = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_last   = 1'b1;
            state_in        = c2hkr_pkg::ST_IDLE;
         end
         default: begin
            state_in = c2hkr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- sv/c2hkr_dpath.sv -----
// c2hkr_dpath: item register, locale tables, table scan, held report and report register
// depends on c2hkr_pkg; commanded by c2hkr_ctrl
module c2hkr_dpath #(
   parameter int ASCII_DEPTH = c2hkr_pkg::ASCII_DEPTH_DEF,
   parameter int UTF8_DEPTH  = c2hkr_pkg::UTF8_DEPTH_DEF,
   parameter int EXT_DEPTH   = c2hkr_pkg::EXT_DEPTH_DEF,
   parameter int KEY_SLOTS   = c2hkr_pkg::KEY_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  c2hkr_pkg::ctl_cmd_type            cmd,
   output c2hkr_pkg::dp_status_type          status,
   input  logic [2:0]                        req_op,
   input  logic [7:0]                        req_byte0,
   input  logic [7:0]                        req_byte1,
   input  logic [7:0]                        req_byte2,
   input  logic [7:0]                        req_byte3,
   input  logic [6:0]                        req_slot_index,
   input  logic [7:0]                        req_mod_bits,
   input  logic [7:0]                        req_key_code,
   input  logic                              csr_wr_en,
   input  logic [c2hkr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_wdata,
   output logic                              rsp_valid,
   output logic [7:0]                        rsp_report_mods,
   output logic [7:0]                        rsp_report_key0,
   output logic [7:0]                        rsp_report_key1,
   output logic [7:0]                        rsp_report_key2,
   output logic [7:0]                        rsp_report_key3,
   output logic [7:0]                        rsp_report_key4,
   output logic [7:0]                        rsp_report_key5,
   output logic [1:0]                        rsp_extra_bytes,
   output logic                              rsp_last
);

   localparam int AAW = (ASCII_DEPTH > 1) ? $clog2(ASCII_DEPTH) : 1;
   localparam int UAW = (UTF8_DEPTH > 1) ? $clog2(UTF8_DEPTH) : 1;
   localparam int XAW = (EXT_DEPTH > 1) ? $clog2(EXT_DEPTH) : 1;
   localparam int SW  = c2hkr_pkg::SCAN_W;
   localparam logic [SW-1:0] ASCII_LIM = SW'(ASCII_DEPTH);
   localparam logic [SW-1:0] UTF8_LIM  = SW'(UTF8_DEPTH);
   localparam logic [SW-1:0] EXT_LIM   = SW'(EXT_DEPTH);

   // tables
   logic [15:0] ascii_mem [ASCII_DEPTH];
   logic [47:0] utf_mem   [UTF8_DEPTH];
   logic [23:0] ext_mem   [EXT_DEPTH];
   logic [15:0] ascii_rd_ff;
   logic [47:0] utf_rd_ff;
   logic [23:0] ext_rd_ff;

   // captured item
   c2hkr_pkg::op_type op_ff;
   logic [31:0]       chr_ff;
   logic [6:0]        idx_ff;
   logic [7:0]        mods_ff;
   logic [7:0]        key_ff;

   // control registers
   logic [7:0] ascii_count_ff;
   logic [6:0] utf8_count_ff;
   logic [6:0] ext_count_ff;

   // scan
   logic [SW-1:0] scan_ff;
   logic          rd_vld_ff;
   logic          utf_more;
   logic          ext_more;
   logic [2:0]    utf_len;
   logic [2:0]    utf_len_m1;

   // selected entry and held report
   logic [7:0] sel_mods_ff;
   logic [7:0] sel_key_ff;
   logic [1:0] sel_extra_ff;
   logic [7:0] held_mods_ff;
   logic [7:0] held_keys_ff [c2hkr_pkg::MAX_SLOTS];
   logic       slot_free;
   logic [2:0] free_idx;

   logic [SW-1:0] idx_ext;
   logic [SW-1:0] b0_ext;
   logic [7:0]    idx8;

   logic [7:0] rsp_keys_ff [c2hkr_pkg::MAX_SLOTS];
   logic [7:0] rsp_mods_ff;
   logic [1:0] rsp_extra_ff;
   logic       rsp_last_ff;
   logic       rsp_valid_ff;

   assign idx8    = {1'b0, idx_ff};
   assign idx_ext = {2'b00, idx_ff};
   assign b0_ext  = {1'b0, chr_ff[7:0]};

   assign utf_more   = (scan_ff < {2'b00, utf8_count_ff}) && (scan_ff < UTF8_LIM);
   assign ext_more   = (scan_ff < {2'b00, ext_count_ff}) && (scan_ff < EXT_LIM);
   assign utf_len    = c2hkr_pkg::match_len(utf_rd_ff[47:16], chr_ff);
   assign utf_len_m1 = utf_len - 3'd1;

   always_comb begin
      slot_free = 1'b0;
      free_idx  = 3'd0;
      for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
         if (held_keys_ff[i] == 8'd0) begin
            slot_free = 1'b1;
            free_idx  = 3'(i);
         end
      end
   end

   assign status.op        = op_ff;
   assign status.ascii_sel = (chr_ff[7:0] < ascii_count_ff) && (b0_ext < ASCII_LIM);
   assign status.utf_hit   = rd_vld_ff && (utf_len != 3'd0);
   assign status.utf_done  = !rd_vld_ff && !utf_more;
   assign status.ext_hit   = rd_vld_ff && (ext_rd_ff[23:16] == chr_ff[7:0]);
   assign status.ext_done  = !rd_vld_ff && !ext_more;
   assign status.slot_free = slot_free;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= c2hkr_pkg::op_type'(req_op);
         chr_ff  <= {req_byte3, req_byte2, req_byte1, req_byte0};
         idx_ff  <= req_slot_index;
         mods_ff <= req_mod_bits;
         key_ff  <= req_key_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ascii_count_ff <= 8'd0;
         utf8_count_ff  <= 7'd0;
         ext_count_ff   <= 7'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            c2hkr_pkg::CSR_ASCII_COUNT: ascii_count_ff <= csr_wdata;
            c2hkr_pkg::CSR_UTF8_COUNT:  utf8_count_ff  <= csr_wdata[6:0];
            c2hkr_pkg::CSR_EXT_COUNT:   ext_count_ff   <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // table writes
   always_ff @(posedge clock) begin
      if (cmd.load && (op_ff == c2hkr_pkg::OP_LOAD_ASCII) && (idx_ext < ASCII_LIM)) begin
         ascii_mem[idx8[AAW-1:0]] <= {mods_ff, key_ff};
      end
      if (cmd.load && (op_ff == c2hkr_pkg::OP_LOAD_UTF8) && (idx_ext < UTF8_LIM)) begin
         utf_mem[idx8[UAW-1:0]] <= {chr_ff, mods_ff, key_ff};
      end
      if (cmd.load && (op_ff == c2hkr_pkg::OP_LOAD_EXT) && (idx_ext < EXT_LIM)) begin
         ext_mem[idx8[XAW-1:0]] <= {chr_ff[7:0], mods_ff, key_ff};
      end
   end

   // table reads
   always_ff @(posedge clock) begin
      if (cmd.ascii_read) begin
         ascii_rd_ff <= ascii_mem[chr_ff[AAW-1:0]];
      end
      if (cmd.scan_utf && utf_more) begin
         utf_rd_ff <= utf_mem[scan_ff[UAW-1:0]];
      end
      if (cmd.scan_ext && ext_more) begin
         ext_rd_ff <= ext_mem[scan_ff[XAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else if (cmd.scan_clear) begin
         scan_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else if (cmd.scan_utf) begin
         rd_vld_ff <= utf_more;
         if (utf_more) begin
            scan_ff <= scan_ff + SW'(1);
         end
      end else if (cmd.scan_ext) begin
         rd_vld_ff <= ext_more;
         if (ext_more) begin
            scan_ff <= scan_ff + SW'(1);
         end
      end else begin
         rd_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sel_extra_ff <= 2'd0;
      end else if (cmd.take_ascii) begin
         sel_mods_ff <= ascii_rd_ff[15:8];
         sel_key_ff  <= ascii_rd_ff[7:0];
      end else if (cmd.take_utf) begin
         sel_mods_ff  <= utf_rd_ff[15:8];
         sel_key_ff   <= utf_rd_ff[7:0];
         sel_extra_ff <= utf_len_m1[1:0];
      end else if (cmd.take_ext) begin
         sel_mods_ff <= ext_rd_ff[15:8];
         sel_key_ff  <= ext_rd_ff[7:0];
      end else if (cmd.take_raw) begin
         sel_mods_ff <= mods_ff;
         sel_key_ff  <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.release_all) begin
         held_mods_ff <= 8'd0;
         for (int i = 0; i < c2hkr_pkg::MAX_SLOTS; i++) begin
            held_keys_ff[i] <= 8'd0;
         end
      end else if (cmd.press) begin
         held_mods_ff           <= held_mods_ff | sel_mods_ff;
         held_keys_ff[free_idx] <= sel_key_ff;
      end else if (cmd.or_mods) begin
         held_mods_ff <= held_mods_ff | key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_mods_ff  <= cmd.release_all ? 8'd0 : held_mods_ff;
         rsp_extra_ff <= sel_extra_ff;
         rsp_last_ff  <= cmd.emit_last;
         for (int i = 0; i < c2hkr_pkg::MAX_SLOTS; i++) begin
            rsp_keys_ff[i] <= cmd.release_all ? 8'd0 : held_keys_ff[i];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_report_mods = rsp_mods_ff;
   assign rsp_report_key0 = rsp_keys_ff[0];
   assign rsp_report_key1 = rsp_keys_ff[1];
   assign rsp_report_key2 = rsp_keys_ff[2];
   assign rsp_report_key3 = rsp_keys_ff[3];
   assign rsp_report_key4 = rsp_keys_ff[4];
   assign rsp_report_key5 = rsp_keys_ff[5];
   assign rsp_extra_bytes = rsp_extra_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ----- sv/char_to_hid_key_report.sv -----
// a load holds busy for a single cycle; a key press steps through dispatch, press and emit,
// a modifier press through dispatch and emit, a release through dispatch and release, and a
// character in the ascii table through dispatch, ascii, press and emit; a character scan
// reads one entry per cycle from each table's port; one item at a time, busy high meanwhile
// reset: synchronous, clears counts, held report and control; tables stay unwritten
// the receiver cannot stall: each report strobes rsp_valid for exactly one cycle
module char_to_hid_key_report #(
   parameter int ASCII_DEPTH = c2hkr_pkg::ASCII_DEPTH_DEF,
   parameter int UTF8_DEPTH  = c2hkr_pkg::UTF8_DEPTH_DEF,
   parameter int EXT_DEPTH   = c2hkr_pkg::EXT_DEPTH_DEF,
   parameter int KEY_SLOTS   = c2hkr_pkg::KEY_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_op,
   input  logic [7:0]                        req_byte0,
   input  logic [7:0]                        req_byte1,
   input  logic [7:0]                        req_byte2,
   input  logic [7:0]                        req_byte3,
   input  logic [6:0]                        req_slot_index,
   input  logic [7:0]                        req_mod_bits,
   input  logic [7:0]                        req_key_code,
   input  logic                              csr_wr_en,
   input  logic [c2hkr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_wdata,
   output logic                              rsp_valid,
   output logic [7:0]                        rsp_report_mods,
   output logic [7:0]                        rsp_report_key0,
   output logic [7:0]                        rsp_report_key1,
   output logic [7:0]                        rsp_report_key2,
   output logic [7:0]                        rsp_report_key3,
   output logic [7:0]                        rsp_report_key4,
   output logic [7:0]                        rsp_report_key5,
   output logic [1:0]                        rsp_extra_bytes,
   output logic                              rsp_last
);

   c2hkr_pkg::ctl_cmd_type   cmd;
   c2hkr_pkg::dp_status_type status;

   c2hkr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   c2hkr_dpath #(
      .ASCII_DEPTH (ASCII_DEPTH),
      .UTF8_DEPTH  (UTF8_DEPTH),
      .EXT_DEPTH   (EXT_DEPTH),
      .KEY_SLOTS   (KEY_SLOTS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_byte0       (req_byte0),
      .req_byte1       (req_byte1),
      .req_byte2       (req_byte2),
      .req_byte3       (req_byte3),
      .req_slot_index  (req_slot_index),
      .req_mod_bits    (req_mod_bits),
      .req_key_code    (req_key_code),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_report_mods (rsp_report_mods),
      .rsp_report_key0 (rsp_report_key0),
      .rsp_report_key1 (rsp_report_key1),
      .rsp_report_key2 (rsp_report_key2),
      .rsp_report_key3 (rsp_report_key3),
      .rsp_report_key4 (rsp_report_key4),
      .rsp_report_key5 (rsp_report_key5),
      .rsp_extra_bytes (rsp_extra_bytes),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- sv/c2hkr_checker.sv -----
// c2hkr_sva: port-level checks of the encoder over time
// depends on char_to_hid_key_report's ports; attached by the bind below
module c2hkr_sva (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_last,
   input logic [7:0] rsp_report_mods,
   input logic [7:0] rsp_report_key0
);

   // an accepted item keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // a report transfer only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("report without work in progress");

   // a non-final report is followed at once by the final all-clear report
   a_type_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=>
         (rsp_valid && rsp_last && (rsp_report_mods == 8'd0) && (rsp_report_key0 == 8'd0)))
      else $error("press report not followed by release report");

   // busy only rises on a start
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without start");

endmodule

bind char_to_hid_key_report c2hkr_sva u_c2hkr_sva (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_last        (rsp_last),
   .rsp_report_mods (rsp_report_mods),
   .rsp_report_key0 (rsp_report_key0)
);

// ----- dv/c2hkr_checker.sv -----
// c2hkr_checker: watches the request, csr and report ports of char_to_hid_key_report,
// predicts every keyboard report and compares it field by field; depends on c2hkr_pkg
`timescale 1ns / 1ps

module c2hkr_checker
   import c2hkr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [2:0]           req_op,
   input  logic [7:0]           req_byte0,
   input  logic [7:0]           req_byte1,
   input  logic [7:0]           req_byte2,
   input  logic [7:0]           req_byte3,
   input  logic [6:0]           req_slot_index,
   input  logic [7:0]           req_mod_bits,
   input  logic [7:0]           req_key_code,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata,
   input  logic                 rsp_valid,
   input  logic [7:0]           rsp_report_mods,
   input  logic [7:0]           rsp_report_key0,
   input  logic [7:0]           rsp_report_key1,
   input  logic [7:0]           rsp_report_key2,
   input  logic [7:0]           rsp_report_key3,
   input  logic [7:0]           rsp_report_key4,
   input  logic [7:0]           rsp_report_key5,
   input  logic [1:0]           rsp_extra_bytes,
   input  logic                 rsp_last,
   output int                   fail_count,
   output int                   reports_waiting
);

   typedef struct packed {
      logic [7:0] mods;
      logic [7:0] key;
   } ascii_entry_t;

   typedef struct packed {
      logic [31:0] code;
      logic [7:0]  mods;
      logic [7:0]  key;
   } utf_entry_t;

   typedef struct packed {
      logic [7:0] code;
      logic [7:0] mods;
      logic [7:0] key;
   } ext_entry_t;

   typedef struct packed {
      logic [7:0]      mods;
      logic [5:0][7:0] keys;
      logic [1:0]      extra;
      logic            last;
   } key_report_t;

   logic [7:0]   ascii_count;
   logic [6:0]   utf8_count;
   logic [6:0]   ext_count;
   logic [7:0]   held_mods;
   logic [7:0]   held_keys [MAX_SLOTS];
   ascii_entry_t ascii_tab [ASCII_DEPTH_DEF];
   utf_entry_t   utf_tab [UTF8_DEPTH_DEF];
   ext_entry_t   ext_tab [EXT_DEPTH_DEF];
   key_report_t  expected_reports [$];

   initial begin
      fail_count      = 0;
      reports_waiting = 0;
   end

   function automatic bit take_slot(input logic [7:0] key, input logic [7:0] mods);
      for (int i = 0; i < KEY_SLOTS_DEF && i < MAX_SLOTS; i++) begin
         if (held_keys[i] == 8'd0) begin
            held_mods    = held_mods | mods;
            held_keys[i] = key;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void clear_held();
      held_mods = 8'd0;
      for (int i = 0; i < MAX_SLOTS; i++) held_keys[i] = 8'd0;
   endfunction

   function automatic key_report_t held_report(input logic [1:0] extra, input logic last);
      key_report_t r;
      r.mods = held_mods;
      for (int i = 0; i < MAX_SLOTS; i++) r.keys[i] = held_keys[i];
      r.extra = extra;
      r.last  = last;
      return r;
   endfunction

   // ascii by index, then first utf8 prefix match, then first extended code match
   function automatic logic [1:0] lookup_char(input logic [31:0] chr, output bit hit);
      int         limit;
      int         matched;
      logic [7:0] c;
      hit = 1'b0;
      if (chr[7:0] < ascii_count && int'(chr[7:0]) < ASCII_DEPTH_DEF) begin
         hit = take_slot(ascii_tab[chr[7:0]].key, ascii_tab[chr[7:0]].mods);
         return 2'd0;
      end
      limit = (utf8_count < UTF8_DEPTH_DEF) ? utf8_count : UTF8_DEPTH_DEF;
      for (int i = 0; i < limit; i++) begin
         matched = 0;
         for (int j = 0; j < CODE_BYTES; j++) begin
            c = utf_tab[i].code[8*j +: 8];
            if (c == 8'd0) break;
            if (c == chr[8*j +: 8]) begin
               matched++;
            end else begin
               matched = 0;
               break;
            end
         end
         if (matched > 0) begin
            hit = take_slot(utf_tab[i].key, utf_tab[i].mods);
            return 2'(matched - 1);
         end
      end
      limit = (ext_count < EXT_DEPTH_DEF) ? ext_count : EXT_DEPTH_DEF;
      for (int i = 0; i < limit; i++) begin
         if (ext_tab[i].code == chr[7:0]) begin
            hit = take_slot(ext_tab[i].key, ext_tab[i].mods);
            return 2'd0;
         end
      end
      return 2'd0;
   endfunction

   always @(posedge clock) begin : monitor
      key_report_t got;
      key_report_t want;
      logic [31:0] chr;
      logic [1:0]  extra;
      bit          hit;
      if (reset) begin
         ascii_count = 8'd0;
         utf8_count  = 7'd0;
         ext_count   = 7'd0;
         clear_held();
         expected_reports.delete();
      end else begin
         if (rsp_valid) begin
            got = {rsp_report_mods, rsp_report_key5, rsp_report_key4, rsp_report_key3,
                   rsp_report_key2, rsp_report_key1, rsp_report_key0, rsp_extra_bytes,
                   rsp_last};
            if (expected_reports.size() == 0) begin
               $display("%0t unexpected report: expected none got %h", $time, got);
               fail_count++;
            end else begin
               want = expected_reports.pop_front();
               if (got.mods !== want.mods) begin
                  $display("%0t report_mods: expected %h got %h", $time, want.mods, got.mods);
                  fail_count++;
               end
               for (int k = 0; k < MAX_SLOTS; k++) begin
                  if (got.keys[k] !== want.keys[k]) begin
                     $display("%0t report_key%0d: expected %h got %h", $time, k,
                              want.keys[k], got.keys[k]);
                     fail_count++;
                  end
               end
               if (got.extra !== want.extra) begin
                  $display("%0t extra_bytes: expected %0d got %0d", $time, want.extra,
                           got.extra);
                  fail_count++;
               end
               if (got.last !== want.last) begin
                  $display("%0t last: expected %0d got %0d", $time, want.last, got.last);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ASCII_COUNT: ascii_count = csr_wdata;
               CSR_UTF8_COUNT:  utf8_count  = csr_wdata[6:0];
               CSR_EXT_COUNT:   ext_count   = csr_wdata[6:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            chr = {req_byte3, req_byte2, req_byte1, req_byte0};
            case (req_op)
               OP_LOAD_ASCII: begin
                  if (int'(req_slot_index) < ASCII_DEPTH_DEF)
                     ascii_tab[req_slot_index] = '{req_mod_bits, req_key_code};
               end
               OP_LOAD_UTF8: begin
                  if (int'(req_slot_index) < UTF8_DEPTH_DEF)
                     utf_tab[req_slot_index] = '{chr, req_mod_bits, req_key_code};
               end
               OP_LOAD_EXT: begin
                  if (int'(req_slot_index) < EXT_DEPTH_DEF)
                     ext_tab[req_slot_index] = '{req_byte0, req_mod_bits, req_key_code};
               end
               OP_PRESS_CHAR: begin
                  extra = lookup_char(chr, hit);
                  if (hit) expected_reports.push_back(held_report(extra, 1'b1));
               end
               OP_TYPE_CHAR: begin
                  extra = lookup_char(chr, hit);
                  if (hit) expected_reports.push_back(held_report(extra, 1'b0));
                  clear_held();
                  expected_reports.push_back(held_report(extra, 1'b1));
               end
               OP_PRESS_KEY: begin
                  if (take_slot(req_key_code, req_mod_bits))
                     expected_reports.push_back(held_report(2'd0, 1'b1));
               end
               OP_PRESS_MOD: begin
                  held_mods = held_mods | req_key_code;
                  expected_reports.push_back(held_report(2'd0, 1'b1));
               end
               default: begin
                  clear_held();
                  expected_reports.push_back(held_report(2'd0, 1'b1));
               end
            endcase
         end
      end
      reports_waiting = expected_reports.size();
   end

endmodule

// ----- dv/tb_char_to_hid_key_report.sv -----
// tb_char_to_hid_key_report: loads the locale tables, sweeps the count registers and drives
// directed and random characters and keys; depends on c2hkr_pkg, the block and c2hkr_checker
`timescale 1ns / 1ps

module tb_char_to_hid_key_report;
   import c2hkr_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int IDLE_WAIT   = 150;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [2:0]           req_op;
   logic [7:0]           req_byte0;
   logic [7:0]           req_byte1;
   logic [7:0]           req_byte2;
   logic [7:0]           req_byte3;
   logic [6:0]           req_slot_index;
   logic [7:0]           req_mod_bits;
   logic [7:0]           req_key_code;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_wdata;
   logic                 rsp_valid;
   logic [7:0]           rsp_report_mods;
   logic [7:0]           rsp_report_key0;
   logic [7:0]           rsp_report_key1;
   logic [7:0]           rsp_report_key2;
   logic [7:0]           rsp_report_key3;
   logic [7:0]           rsp_report_key4;
   logic [7:0]           rsp_report_key5;
   logic [1:0]           rsp_extra_bytes;
   logic                 rsp_last;
   int                   fail_count;
   int                   reports_waiting;
   int                   cycle_count;

   // stimulus-side copy of loaded codes and which entries hold data
   logic [127:0] ascii_loaded;
   logic [127:0] utf_loaded;
   logic [127:0] ext_loaded;
   logic [31:0]  utf_codes [UTF8_DEPTH_DEF];
   logic [7:0]   ext_codes [EXT_DEPTH_DEF];
   int           cur_ascii;
   int           cur_utf;
   int           cur_ext;
   int           burst_left;

   char_to_hid_key_report dut (
      .clock, .reset, .start, .busy,
      .req_op, .req_byte0, .req_byte1, .req_byte2, .req_byte3,
      .req_slot_index, .req_mod_bits, .req_key_code,
      .csr_wr_en, .csr_index, .csr_wdata,
      .rsp_valid, .rsp_report_mods,
      .rsp_report_key0, .rsp_report_key1, .rsp_report_key2,
      .rsp_report_key3, .rsp_report_key4, .rsp_report_key5,
      .rsp_extra_bytes, .rsp_last
   );

   c2hkr_checker scoreboard (
      .clock, .reset, .start, .busy,
      .req_op, .req_byte0, .req_byte1, .req_byte2, .req_byte3,
      .req_slot_index, .req_mod_bits, .req_key_code,
      .csr_wr_en, .csr_index, .csr_wdata,
      .rsp_valid, .rsp_report_mods,
      .rsp_report_key0, .rsp_report_key1, .rsp_report_key2,
      .rsp_report_key3, .rsp_report_key4, .rsp_report_key5,
      .rsp_extra_bytes, .rsp_last,
      .fail_count, .reports_waiting
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int lead_ones(input logic [127:0] v);
      int n;
      n = 0;
      while (n < 128 && v[n]) n++;
      return n;
   endfunction

   function automatic logic [6:0] pick_index(input int loaded, input int depth);
      if ($urandom_range(0, 1) == 1 && loaded < depth) return 7'(loaded);
      return 7'($urandom_range(0, 127));
   endfunction

   // code of 0..4 nonzero bytes; bytes after the terminating zero are junk
   function automatic logic [31:0] make_code();
      logic [31:0] c;
      int          len;
      c = $urandom;
      if ($urandom_range(0, 4) == 0) return c;
      len = $urandom_range(0, 4);
      for (int j = 0; j < CODE_BYTES; j++) begin
         if (j < len) c[8*j +: 8] = 8'($urandom_range(1, 255));
         else if (j == len) c[8*j +: 8] = 8'd0;
      end
      return c;
   endfunction

   function automatic logic [31:0] pick_char();
      logic [31:0] c;
      int          sel;
      int          i;
      c   = $urandom;
      sel = $urandom_range(0, 9);
      if (sel < 2 && cur_ascii > 0) begin
         c[7:0] = 8'($urandom_range(0, ((cur_ascii < 128) ? cur_ascii : 128) - 1));
      end else if (sel < 6 && cur_utf > 0) begin
         i = $urandom_range(0, ((cur_utf < 64) ? cur_utf : 64) - 1);
         for (int j = 0; j < CODE_BYTES; j++) begin
            if (utf_codes[i][8*j +: 8] == 8'd0) break;
            c[8*j +: 8] = utf_codes[i][8*j +: 8];
         end
         if ($urandom_range(0, 9) == 0) c[15:8] = c[15:8] ^ (8'd1 << $urandom_range(0, 7));
      end else if (sel < 8 && cur_ext > 0) begin
         c[7:0] = ext_codes[$urandom_range(0, ((cur_ext < 64) ? cur_ext : 64) - 1)];
      end
      return c;
   endfunction

   task automatic send_item(input op_type op, input logic [31:0] chr, input logic [6:0] idx,
                            input logic [7:0] mods, input logic [7:0] key);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 20);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end else begin
         @(negedge clock);
      end
      burst_left--;
      start          <= 1'b1;
      req_op         <= op;
      req_byte0      <= chr[7:0];
      req_byte1      <= chr[15:8];
      req_byte2      <= chr[23:16];
      req_byte3      <= chr[31:24];
      req_slot_index <= idx;
      req_mod_bits   <= mods;
      req_key_code   <= key;
      case (op)
         OP_LOAD_ASCII: ascii_loaded[idx] = 1'b1;
         OP_LOAD_UTF8: begin
            if (idx < UTF8_DEPTH_DEF) begin
               utf_loaded[idx] = 1'b1;
               utf_codes[idx]  = chr;
            end
         end
         OP_LOAD_EXT: begin
            if (idx < EXT_DEPTH_DEF) begin
               ext_loaded[idx] = 1'b1;
               ext_codes[idx]  = chr[7:0];
            end
         end
         default: ;
      endcase
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (reports_waiting != 0 || busy) @(negedge clock);
      repeat (IDLE_WAIT) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_ASCII_COUNT: cur_ascii = data;
         CSR_UTF8_COUNT:  cur_utf   = data[6:0];
         CSR_EXT_COUNT:   cur_ext   = data[6:0];
         default: ;
      endcase
   endtask

   initial begin : stimulus
      logic [31:0] chr;
      logic [6:0]  idx;
      logic [7:0]  mods;
      logic [7:0]  key;
      int          pick;
      reset          = 1'b1;
      start          = 1'b0;
      req_op         = OP_RELEASE;
      req_byte0      = 8'd0;
      req_byte1      = 8'd0;
      req_byte2      = 8'd0;
      req_byte3      = 8'd0;
      req_slot_index = 7'd0;
      req_mod_bits   = 8'd0;
      req_key_code   = 8'd0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_ASCII_COUNT;
      csr_wdata      = 8'd0;
      ascii_loaded   = '0;
      utf_loaded     = '0;
      ext_loaded     = '0;
      cur_ascii      = 0;
      cur_utf        = 0;
      cur_ext        = 0;
      burst_left     = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // held report: release, zero key code, full slots, modifier press
      send_item(OP_RELEASE, 32'h0, 7'd0, 8'h00, 8'h00);
      send_item(OP_PRESS_KEY, 32'h0, 7'd0, 8'hFF, 8'h00);
      send_item(OP_PRESS_KEY, 32'h0, 7'd0, 8'h00, 8'hFF);
      send_item(OP_PRESS_MOD, 32'h0, 7'd0, 8'h00, 8'h80);
      for (int i = 0; i < 5; i++)
         send_item(OP_PRESS_KEY, 32'h0, 7'd0, 8'(1 << i), 8'(8'h10 + i));
      send_item(OP_PRESS_KEY, 32'h0, 7'd0, 8'h7F, 8'h11);
      send_item(OP_TYPE_CHAR, 32'h0000_0041, 7'd0, 8'h00, 8'h00);

      // table loads, including empty code and out of range indexes
      send_item(OP_LOAD_ASCII, 32'h0, 7'd0, 8'h02, 8'h04);
      send_item(OP_LOAD_ASCII, 32'h0, 7'd127, 8'hFF, 8'hFF);
      send_item(OP_LOAD_UTF8, 32'h0000_A9C3, 7'd0, 8'h40, 8'h08);
      send_item(OP_LOAD_UTF8, 32'h0000_4100, 7'd1, 8'h01, 8'h09);
      send_item(OP_LOAD_UTF8, 32'h8098_9FF0, 7'd2, 8'h20, 8'h0A);
      send_item(OP_LOAD_UTF8, 32'h0000_00C3, 7'd100, 8'h01, 8'h0B);
      send_item(OP_LOAD_EXT, 32'h0000_00E9, 7'd0, 8'h04, 8'h0C);
      send_item(OP_LOAD_EXT, 32'h0000_00E9, 7'd127, 8'h08, 8'h0D);

      wait_idle();
      write_csr(CSR_ASCII_COUNT, 8'd1);
      write_csr(CSR_UTF8_COUNT, 8'd3);
      write_csr(CSR_EXT_COUNT, 8'd1);
      send_item(OP_PRESS_CHAR, 32'h0000_0000, 7'd0, 8'h00, 8'h00);
      send_item(OP_TYPE_CHAR, 32'h5A00_A9C3, 7'd0, 8'h00, 8'h00);
      send_item(OP_PRESS_CHAR, 32'h8098_9FF0, 7'd0, 8'h00, 8'h00);
      send_item(OP_PRESS_CHAR, 32'h0000_00E9, 7'd0, 8'h00, 8'h00);
      send_item(OP_RELEASE, 32'h0, 7'd0, 8'h00, 8'h00);

      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 6) begin
            for (int i = 0; i < ASCII_DEPTH_DEF; i++)
               if (!ascii_loaded[i])
                  send_item(OP_LOAD_ASCII, $urandom, 7'(i), 8'($urandom), 8'($urandom));
            for (int i = 0; i < UTF8_DEPTH_DEF; i++)
               if (!utf_loaded[i])
                  send_item(OP_LOAD_UTF8, make_code(), 7'(i), 8'($urandom), 8'($urandom));
            for (int i = 0; i < EXT_DEPTH_DEF; i++)
               if (!ext_loaded[i])
                  send_item(OP_LOAD_EXT, $urandom, 7'(i), 8'($urandom), 8'($urandom));
         end
         wait_idle();
         case (phase)
            0: begin
               write_csr(CSR_ASCII_COUNT, 8'd0);
               write_csr(CSR_UTF8_COUNT, 8'd0);
               write_csr(CSR_EXT_COUNT, 8'd0);
            end
            1: begin
               write_csr(CSR_ASCII_COUNT, 8'(lead_ones(ascii_loaded)));
               write_csr(CSR_UTF8_COUNT, 8'(lead_ones(utf_loaded)));
               write_csr(CSR_EXT_COUNT, 8'(lead_ones(ext_loaded)));
            end
            6: begin
               write_csr(CSR_ASCII_COUNT, 8'd128);
               write_csr(CSR_UTF8_COUNT, 8'd64);
               write_csr(CSR_EXT_COUNT, 8'd64);
            end
            7: begin
               write_csr(CSR_ASCII_COUNT, 8'hFF);
               write_csr(CSR_UTF8_COUNT, 8'hFF);
               write_csr(CSR_EXT_COUNT, 8'hC0);
               write_csr(CSR_UNUSED, 8'($urandom));
            end
            8, 9: begin
               write_csr(CSR_ASCII_COUNT, 8'($urandom));
               write_csr(CSR_UTF8_COUNT, 8'($urandom));
               write_csr(CSR_EXT_COUNT, 8'($urandom));
            end
            default: begin
               write_csr(CSR_ASCII_COUNT, 8'($urandom_range(0, lead_ones(ascii_loaded))));
               write_csr(CSR_UTF8_COUNT, 8'($urandom_range(0, lead_ones(utf_loaded))));
               write_csr(CSR_EXT_COUNT, 8'($urandom_range(0, lead_ones(ext_loaded))));
            end
         endcase
         for (int n = 0; n < 50; n++) begin
            chr  = $urandom;
            idx  = 7'($urandom_range(0, 127));
            mods = 8'($urandom);
            key  = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 7) begin
               send_item(OP_LOAD_ASCII, chr, pick_index(lead_ones(ascii_loaded), 128), mods,
                         key);
            end else if (pick < 14) begin
               send_item(OP_LOAD_UTF8, make_code(), pick_index(lead_ones(utf_loaded), 64),
                         mods, key);
            end else if (pick < 19) begin
               send_item(OP_LOAD_EXT, chr, pick_index(lead_ones(ext_loaded), 64), mods, key);
            end else if (pick < 45) begin
               send_item(OP_PRESS_CHAR, pick_char(), idx, mods, key);
            end else if (pick < 62) begin
               send_item(OP_TYPE_CHAR, pick_char(), idx, mods, key);
            end else if (pick < 76) begin
               if ($urandom_range(0, 9) == 0) key = 8'd0;
               send_item(OP_PRESS_KEY, chr, idx, mods, key);
            end else if (pick < 82) begin
               send_item(OP_PRESS_MOD, chr, idx, mods, key);
            end else begin
               send_item(OP_RELEASE, chr, idx, mods, key);
            end
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
